>>> hw/rtl/fixed_record_block_packer_defines.svh
// Assertion macros for the record block packer.
`ifndef FIXED_RECORD_BLOCK_PACKER_DEFINES_SVH
`define FIXED_RECORD_BLOCK_PACKER_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define FRBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition never holds at any clock edge outside reset.
`define FRBP_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

>>> hw/rtl/frbp_pkg.sv
// Types, constants and a helper function shared by the record block packer.
`timescale 1ns / 1ps

package frbp_pkg;

    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] MAX_BLOCK = 12'd2048;
    localparam logic [CNT_W-1:0] MIN_BLOCK = 12'd18;
    localparam logic [CNT_W-1:0] SAT_MAX   = 12'd4095;

    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_FILL = 8'd94;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic MODE_FIXED     = 1'b0;
    localparam logic MODE_UNDEFINED = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd2;

    localparam logic [CNT_W-1:0] RST_BLOCK_LENGTH  = 12'd1920;
    localparam logic [CNT_W-1:0] RST_RECORD_LENGTH = 12'd80;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int LVL_W      = 3;

    typedef struct packed {
        logic             format_mode;
        logic [CNT_W-1:0] block_length;
        logic [CNT_W-1:0] record_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       run_byte;
        logic [CNT_W-1:0] run_count;
        logic             block_end;
        logic             last;
    } run_t;

    typedef struct packed {
        logic has0;
        logic has1;
        run_t run0;
        run_t run1;
    } push_t;

    typedef struct packed {
        logic in_valid;
        logic process;
    } core_status_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/frbp_core.sv
// Input register, stream state and per-transaction run generation.
`timescale 1ns / 1ps

module frbp_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [7:0]                  s_data_byte,
    input  frbp_pkg::cfg_t              cfg,
    input  logic                        room,
    output frbp_pkg::push_t             push,
    output frbp_pkg::core_status_t      status
);

    logic                       in_valid_reg, in_valid_next;
    logic                       kind_reg, kind_next;
    logic [7:0]                 byte_reg, byte_next;
    logic [frbp_pkg::CNT_W-1:0] record_pos_reg, record_pos_next;
    logic [frbp_pkg::CNT_W-1:0] block_fill_reg, block_fill_next;
    logic                       record_open_reg, record_open_next;
    logic                       process;

    logic [frbp_pkg::CNT_W-1:0] blen, pad, adv, fill_new, pos_new;
    logic [3:0]                 adv4;
    logic                       open_new, has0, has1, close;
    frbp_pkg::run_t             r0, r1;

    assign process = in_valid_reg && room;
    assign s_ready = !in_valid_reg || process;

    always_comb begin
        blen = (cfg.block_length > frbp_pkg::MAX_BLOCK) ? frbp_pkg::MAX_BLOCK
                                                         : cfg.block_length;
        pad  = (record_pos_reg < cfg.record_length) ? cfg.record_length - record_pos_reg
                                                    : '0;
        adv4 = 4'd8 - {1'b0, record_pos_reg[2:0]};
        adv  = {{(frbp_pkg::CNT_W-4){1'b0}}, adv4};

        fill_new = block_fill_reg;
        pos_new  = record_pos_reg;
        open_new = record_open_reg;
        has0     = 1'b0;
        close    = 1'b0;
        r0       = '{run_byte: byte_reg, run_count: 12'd1, block_end: 1'b0, last: 1'b0};

        if (kind_reg == frbp_pkg::KIND_DATA) begin
            has0 = 1'b1;
            if (cfg.format_mode == frbp_pkg::MODE_UNDEFINED) begin
                fill_new = frbp_pkg::sat_add(block_fill_reg, 12'd1);
                close    = fill_new >= blen;
            end else if (byte_reg == frbp_pkg::CH_NL) begin
                fill_new     = frbp_pkg::sat_add(block_fill_reg, pad);
                r0.run_byte  = frbp_pkg::CH_SP;
                r0.run_count = pad;
                pos_new      = '0;
                open_new     = 1'b0;
                close        = fill_new >= blen;
            end else if (byte_reg == frbp_pkg::CH_TAB) begin
                pos_new      = frbp_pkg::sat_add(record_pos_reg, adv);
                fill_new     = frbp_pkg::sat_add(block_fill_reg, adv);
                open_new     = 1'b1;
                r0.run_byte  = frbp_pkg::CH_SP;
                r0.run_count = adv;
            end else begin
                pos_new  = frbp_pkg::sat_add(record_pos_reg, 12'd1);
                fill_new = frbp_pkg::sat_add(block_fill_reg, 12'd1);
                open_new = 1'b1;
            end
        end else begin
            if (cfg.format_mode == frbp_pkg::MODE_FIXED && record_open_reg) begin
                has0         = 1'b1;
                fill_new     = frbp_pkg::sat_add(block_fill_reg, pad);
                r0.run_byte  = frbp_pkg::CH_SP;
                r0.run_count = pad;
            end
            pos_new  = '0;
            open_new = 1'b0;
            close    = fill_new != '0;
        end

        has1 = close && ((fill_new < frbp_pkg::MIN_BLOCK) || !has0);
        r1   = '{run_byte: frbp_pkg::CH_FILL, run_count: '0, block_end: 1'b1, last: 1'b1};
        if (fill_new < frbp_pkg::MIN_BLOCK) begin
            r1.run_count = frbp_pkg::MIN_BLOCK - fill_new;
        end
        r0.block_end = close && !has1;
        r0.last      = !has1;
    end

    assign push.has0 = process && has0;
    assign push.has1 = process && has1;
    assign push.run0 = r0;
    assign push.run1 = r1;

    assign status.in_valid = in_valid_reg;
    assign status.process  = process;

    always_comb begin
        in_valid_next    = in_valid_reg;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        record_pos_next  = record_pos_reg;
        block_fill_next  = block_fill_reg;
        record_open_next = record_open_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (s_valid && s_ready) begin
            kind_next = s_kind;
            byte_next = s_data_byte;
        end
        if (process) begin
            record_pos_next  = pos_new;
            block_fill_next  = close ? '0 : fill_new;
            record_open_next = open_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            record_pos_reg  <= '0;
            block_fill_reg  <= '0;
            record_open_reg <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            record_pos_reg  <= record_pos_next;
            block_fill_reg  <= block_fill_next;
            record_open_reg <= record_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

endmodule

>>> hw/rtl/frbp_result_fifo.sv
// Small result queue that takes up to two runs per cycle and hands out one.
`timescale 1ns / 1ps

module frbp_result_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  frbp_pkg::push_t              push,
    output logic                         room,
    output logic [frbp_pkg::LVL_W-1:0]   level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output frbp_pkg::run_t               m_run
);

    frbp_pkg::run_t                 mem_reg [frbp_pkg::FIFO_DEPTH];
    logic [frbp_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [frbp_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [frbp_pkg::LVL_W-1:0]     level_reg, level_next;
    logic [frbp_pkg::PTR_W-1:0]     wr_ptr_b;
    logic [frbp_pkg::LVL_W-1:0]     push_n;
    logic                           pop, push_a, push_b;
    frbp_pkg::run_t                 entry_a;

    assign m_valid = level_reg != '0;
    assign m_run   = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign room    = level_reg <= frbp_pkg::LVL_W'(frbp_pkg::FIFO_DEPTH - 2);
    assign level   = level_reg;

    assign push_a  = push.has0 || push.has1;
    assign push_b  = push.has0 && push.has1;
    assign entry_a = push.has0 ? push.run0 : push.run1;
    assign wr_ptr_b = wr_ptr_reg + 1'b1;
    assign push_n  = {{(frbp_pkg::LVL_W-1){1'b0}}, push_a}
                   + {{(frbp_pkg::LVL_W-1){1'b0}}, push_b};

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n[frbp_pkg::PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + {{(frbp_pkg::PTR_W-1){1'b0}}, pop};
        level_next  = level_reg + push_n - {{(frbp_pkg::LVL_W-1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem_reg[wr_ptr_reg] <= entry_a;
        end
        if (push_b) begin
            mem_reg[wr_ptr_b] <= push.run1;
        end
    end

endmodule

>>> hw/rtl/fixed_record_block_packer.sv
// An accepted transaction waits in the input register until the queue has room for its runs.
// Throughput: one input transaction per cycle while each gives one run and m_ready holds; the result
// port moves one run per cycle, so two-run transactions set the pace through the queue.
// Reset: synchronous, active low; clears stream state and queue and loads configuration defaults.
`timescale 1ns / 1ps
`include "fixed_record_block_packer_defines.svh"

module fixed_record_block_packer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [frbp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frbp_pkg::CNT_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_run_byte,
    output logic [frbp_pkg::CNT_W-1:0]         m_run_count,
    output logic                               m_block_end,
    output logic                               m_last
);

    frbp_pkg::cfg_t             cfg_reg, cfg_next;
    frbp_pkg::push_t            push;
    frbp_pkg::core_status_t     status;
    frbp_pkg::run_t             m_run;
    logic                       room;
    logic [frbp_pkg::LVL_W-1:0] level;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                frbp_pkg::CFG_FORMAT_MODE:   cfg_next.format_mode   = cfg_data[0];
                frbp_pkg::CFG_BLOCK_LENGTH:  cfg_next.block_length  = cfg_data;
                frbp_pkg::CFG_RECORD_LENGTH: cfg_next.record_length = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_mode   <= frbp_pkg::MODE_FIXED;
            cfg_reg.block_length  <= frbp_pkg::RST_BLOCK_LENGTH;
            cfg_reg.record_length <= frbp_pkg::RST_RECORD_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    frbp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .cfg         (cfg_reg),
        .room        (room),
        .push        (push),
        .status      (status)
    );

    frbp_result_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .level   (level),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_run   (m_run)
    );

    assign m_run_byte  = m_run.run_byte;
    assign m_run_count = m_run.run_count;
    assign m_block_end = m_run.block_end;
    assign m_last      = m_run.last;

    // The queue never holds more runs than it has entries.
    `FRBP_NEVER(a_level_bound, level > frbp_pkg::LVL_W'(frbp_pkg::FIFO_DEPTH), "queue overflow")
    // A transaction is only processed when the queue can take both of its runs.
    `FRBP_NEVER(a_push_room, (push.has0 || push.has1) && !room, "push without room")
    // Any second run is a closing filler run that ends the block and is marked last.
    `FRBP_ASSERT(a_single_close, push.has1 |-> push.run1.block_end && push.run1.last, "bad close run")
    // A held transaction in the input register is not lost while the queue has no room for it.
    `FRBP_ASSERT(a_hold_input, (status.in_valid && !status.process) |=> status.in_valid, "input dropped")

endmodule
